// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion shorthands used by the histogram rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ubh_pkg.sv =====
// ----------------------------------------------------------------------------
// ubh_pkg
// widths, register codes and interface structs of the uniform bin histogram
// ----------------------------------------------------------------------------
`default_nettype none

package ubh_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ADDEND_W   = 32;
    localparam int BIN_W      = 6;
    localparam int TOTAL_W    = 64;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 5;
    // n * width + remainder stays below 2^39
    localparam int LIMIT_W    = 39;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 2'd2;

    // reset values of the registers
    localparam logic [SAMPLE_W-1:0] LOWER_RESET = 32'd0;
    localparam logic [SAMPLE_W-1:0] UPPER_RESET = 32'd64;
    localparam logic [COUNT_W-1:0]  COUNT_RESET = 6'd8;

    typedef struct packed {
        logic                req;
        logic [BIN_W-1:0]    bin;
        logic [ADDEND_W-1:0] addend;
    } bank_req_t;

    typedef struct packed {
        logic clearing;
        logic done;
    } bank_status_t;

endpackage

`default_nettype wire

// ===== hdl/uniform_bin_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// uniform_bin_histogram_unit
// histogram of equal-width bins, plus an optional extra bin, with 64-bit wrapping counters
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one transfer carries a sample index and an addend; the addend
//   is added to the counter of the bin that holds the index
//   m_ channel: one transfer per input with the bin used, its new total and
//   a clamp flag in tuser
//   cfg channel: writes lower bound, upper bound and bin count; every write
//   restarts the bin geometry computation, with s_tready low meanwhile
// processing
//   an in-range sample takes 32 serial divide steps of the offset by the bin
//   width, then the bin is picked, then the counter memory does its
//   read-add-write and the result loads the output register; samples below
//   the range skip the divide; the next input is taken once the last is through
// reset
//   registers return to lower 0, upper 64, count 8; a clearing pass zeroes
//   every counter slot while s_tready stays low, overlapped with the
//   geometry computation
// stall
//   one output register holds the result; the next item is accepted and
//   divided meanwhile, and waits before its counter update until the
//   receiver takes the pending result
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uniform_bin_histogram_unit #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [63:0]                      s_tdata,   // sample_index, addend
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [71:0]                           m_tdata,   // bin_number, bin_total
    output logic                                  m_tuser,   // was_clamped
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ubh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ubh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [8:0] {
        ST_GEO   = 9'b0_0000_0001,  // start domain / count
        ST_GDIV1 = 9'b0_0000_0010,  // wait for quotient, round up to width
        ST_GREM  = 9'b0_0000_0100,  // start domain / width
        ST_GDIV2 = 9'b0_0000_1000,  // wait for remainder (extra bin width)
        ST_GMUL  = 9'b0_0001_0000,  // end of extra bin
        ST_IDLE  = 9'b0_0010_0000,
        ST_DIV   = 9'b0_0100_0000,  // offset / width in flight
        ST_ISSUE = 9'b0_1000_0000,  // counter update once output is free
        ST_WAIT  = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [ubh_pkg::SAMPLE_W-1:0] lower_reg;
    logic [ubh_pkg::SAMPLE_W-1:0] upper_reg;
    logic [ubh_pkg::COUNT_W-1:0]  count_reg;

    // geometry
    logic [ubh_pkg::DIV_W-1:0]    width_reg, width_next;
    logic [ubh_pkg::DIV_W-1:0]    extra_w_reg, extra_w_next;
    logic                         extra_reg, extra_next;
    logic [ubh_pkg::LIMIT_W-1:0]  limit_reg, limit_next;

    // item in flight
    logic [ubh_pkg::SAMPLE_W-1:0] off_reg, off_next;
    logic [ubh_pkg::ADDEND_W-1:0] addend_reg, addend_next;
    logic [ubh_pkg::BIN_W-1:0]    bin_reg, bin_next;
    logic                         clamp_reg, clamp_next;

    // output register
    logic                         m_tvalid_reg;
    logic [ubh_pkg::BIN_W-1:0]    out_bin_reg;
    logic [ubh_pkg::TOTAL_W-1:0]  out_total_reg;
    logic                         out_clamp_reg;
    logic                         out_load;

    logic                         cfg_write;
    logic                         s_accept;
    logic [ubh_pkg::COUNT_W-1:0]  n_eff;
    logic                         domain_ok;
    logic [ubh_pkg::SAMPLE_W-1:0] domain;
    logic [ubh_pkg::SAMPLE_W-1:0] s_index;
    logic [ubh_pkg::ADDEND_W-1:0] s_addend;
    logic [ubh_pkg::SAMPLE_W-1:0] s_offset;

    logic                         div_start;
    logic [ubh_pkg::DIV_W-1:0]    div_dividend;
    logic [ubh_pkg::DIV_W-1:0]    div_divisor;
    logic                         div_done;
    logic [ubh_pkg::DIV_W-1:0]    div_quot;
    logic [ubh_pkg::DIV_W-1:0]    div_rem;

    ubh_pkg::bank_req_t           bank_req;
    ubh_pkg::bank_status_t        bank_status;
    logic [ubh_pkg::TOTAL_W-1:0]  bank_total;

    assign s_index   = s_tdata[31:0];
    assign s_addend  = s_tdata[63:32];
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE) && !bank_status.clearing;
    assign s_accept  = s_tvalid && s_tready;

    // effective regular bin count: zero reads as one, capped at the counter slots
    always_comb begin
        n_eff = (count_reg == '0) ? ubh_pkg::COUNT_W'(1) : count_reg;
        if (32'(n_eff) > 32'(MAX_BINS)) begin
            n_eff = ubh_pkg::COUNT_W'(MAX_BINS);
        end
    end

    assign domain_ok = upper_reg > lower_reg;
    assign domain    = upper_reg - lower_reg;
    assign s_offset  = s_index - lower_reg;

    // configuration writes, index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= ubh_pkg::LOWER_RESET;
            upper_reg <= ubh_pkg::UPPER_RESET;
            count_reg <= ubh_pkg::COUNT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                ubh_pkg::REG_LOWER_BOUND: lower_reg <= cfg_data;
                ubh_pkg::REG_UPPER_BOUND: upper_reg <= cfg_data;
                ubh_pkg::REG_BIN_COUNT:   count_reg <= cfg_data[ubh_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        width_next   = width_reg;
        extra_w_next = extra_w_reg;
        extra_next   = extra_reg;
        limit_next   = limit_reg;
        off_next     = off_reg;
        addend_next  = addend_reg;
        bin_next     = bin_reg;
        clamp_next   = clamp_reg;
        div_start    = 1'b0;
        div_dividend = domain;
        div_divisor  = width_reg;
        out_load     = 1'b0;
        bank_req     = '{req: 1'b0, bin: bin_reg, addend: addend_reg};

        unique case (state_reg)
            ST_GEO: begin
                if (domain_ok) begin
                    div_start   = 1'b1;
                    div_divisor = ubh_pkg::DIV_W'(n_eff);
                    state_next  = ST_GDIV1;
                end else begin
                    // empty or inverted domain: everything clamps to bin 0
                    width_next   = '0;
                    extra_w_next = '0;
                    extra_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_GDIV1: begin
                if (div_done) begin
                    // ceiling of domain / count
                    width_next = div_quot + ubh_pkg::DIV_W'(div_rem != '0);
                    state_next = ST_GREM;
                end
            end
            ST_GREM: begin
                div_start  = 1'b1;
                state_next = ST_GDIV2;
            end
            ST_GDIV2: begin
                if (div_done) begin
                    extra_w_next = div_rem;
                    extra_next   = (div_rem != '0) && (32'(n_eff) < 32'(MAX_BINS));
                    state_next   = ST_GMUL;
                end
            end
            ST_GMUL: begin
                limit_next = ubh_pkg::LIMIT_W'(n_eff) * ubh_pkg::LIMIT_W'(width_reg)
                           + ubh_pkg::LIMIT_W'(extra_w_reg);
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    addend_next = s_addend;
                    off_next    = s_offset;
                    if (!domain_ok || (s_index < lower_reg)) begin
                        // below the range or no domain
                        bin_next   = '0;
                        clamp_next = 1'b1;
                        state_next = ST_ISSUE;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = s_offset;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    priority if (div_quot < ubh_pkg::DIV_W'(n_eff)) begin
                        bin_next   = div_quot[ubh_pkg::BIN_W-1:0];
                        clamp_next = 1'b0;
                    end else if (extra_reg && (ubh_pkg::LIMIT_W'(off_reg) < limit_reg)) begin
                        bin_next   = n_eff;
                        clamp_next = 1'b0;
                    end else begin
                        // past all bins: last bin, extra one if present
                        bin_next   = extra_reg ? n_eff : n_eff - 1'b1;
                        clamp_next = 1'b1;
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // output register is empty after this edge
                if (!m_tvalid_reg || m_tready) begin
                    bank_req.req = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (bank_status.done) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_GEO;
            end
        endcase

        // any register write restarts the geometry
        if (cfg_write) begin
            state_next = ST_GEO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_GEO;
            extra_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg   <= width_next;
        extra_w_reg <= extra_w_next;
        limit_reg   <= limit_next;
        off_reg     <= off_next;
        addend_reg  <= addend_next;
        bin_reg     <= bin_next;
        clamp_reg   <= clamp_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bin_reg   <= bin_reg;
            out_total_reg <= bank_total;
            out_clamp_reg <= clamp_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_total_reg, out_bin_reg};
    assign m_tuser  = out_clamp_reg;

    ubh_serial_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ubh_counter_bank #(
        .MAX_BINS (MAX_BINS)
    ) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bank_req),
        .status  (bank_status),
        .total   (bank_total)
    );

    // counter update answers with done after its add phase writes the sum
    `ASSERT_IMPL(a_bank_latency, aclk, aresetn, bank_req.req, ##2 bank_status.done)
    // a finished update never lands on a pending result
    `ASSERT_IMPL(a_out_free, aclk, aresetn, bank_status.done, !m_tvalid_reg)
    // a register write always restarts the geometry
    `ASSERT_NEXT(a_cfg_restart, aclk, aresetn, cfg_write, state_reg == ST_GEO)
    // an accepted item always leaves idle
    `ASSERT_NEXT(a_item_leaves_idle, aclk, aresetn, s_accept, state_reg != ST_IDLE)

endmodule

`default_nettype wire

// ===== hdl/ubh_serial_div.sv =====
// ----------------------------------------------------------------------------
// ubh_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_serial_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ubh_pkg::DIV_W-1:0] dividend,
    input  wire logic [ubh_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [ubh_pkg::DIV_W-1:0]      quotient,
    output logic [ubh_pkg::DIV_W-1:0]      remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ubh_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [ubh_pkg::DIV_W-1:0]     quot_reg;
    logic [ubh_pkg::DIV_W-1:0]     rem_reg;
    logic [ubh_pkg::DIV_W-1:0]     divisor_reg;

    logic [ubh_pkg::DIV_W:0]       rem_shift;
    logic [ubh_pkg::DIV_W+1:0]     diff;

    // dividend bits leave at the top of quot_reg as quotient bits enter below
    always_comb begin
        rem_shift = {rem_reg, quot_reg[ubh_pkg::DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ubh_pkg::DIV_CNT_W'(ubh_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[ubh_pkg::DIV_W+1]) begin
                rem_reg  <= diff[ubh_pkg::DIV_W-1:0];
                quot_reg <= {quot_reg[ubh_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift[ubh_pkg::DIV_W-1:0];
                quot_reg <= {quot_reg[ubh_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/ubh_counter_bank.sv =====
// ----------------------------------------------------------------------------
// ubh_counter_bank
// bin counter memory with read-add-write update and clearing pass at reset
// ----------------------------------------------------------------------------
`default_nettype none

module ubh_counter_bank #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ubh_pkg::bank_req_t          req,
    output ubh_pkg::bank_status_t            status,
    output logic [ubh_pkg::TOTAL_W-1:0]      total
);

    localparam int ADDR_W = $clog2(MAX_BINS);

    logic [ubh_pkg::TOTAL_W-1:0]  mem [MAX_BINS];

    logic                         clearing_reg;
    logic [ADDR_W-1:0]            clr_idx_reg;
    logic                         add_phase_reg;
    logic                         done_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [ubh_pkg::ADDEND_W-1:0] addend_reg;
    logic [ubh_pkg::TOTAL_W-1:0]  rd_data_reg;
    logic [ubh_pkg::TOTAL_W-1:0]  total_reg;

    logic [ubh_pkg::TOTAL_W-1:0]  sum;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ubh_pkg::TOTAL_W-1:0]  wr_data;

    always_comb begin
        sum = rd_data_reg + {{(ubh_pkg::TOTAL_W - ubh_pkg::ADDEND_W){1'b0}}, addend_reg};
        if (clearing_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end else begin
            wr_en   = add_phase_reg;
            wr_addr = addr_reg;
            wr_data = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            add_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(MAX_BINS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            add_phase_reg <= req.req;
            done_reg      <= add_phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.req) begin
            rd_data_reg <= mem[ADDR_W'(req.bin)];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.req) begin
            addr_reg   <= ADDR_W'(req.bin);
            addend_reg <= req.addend;
        end
        if (add_phase_reg) begin
            total_reg <= sum;
        end
    end

    assign status.clearing = clearing_reg;
    assign status.done     = done_reg;
    assign total           = total_reg;

endmodule

`default_nettype wire
